// ===== rtl/core/lp2c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lp2c_pkg
// Shared constants, tables and types of the lidar polar to Cartesian block.
// ----------------------------------------------------------------------------
package lp2c_pkg;

  localparam int CordicStages = 16;
  localparam int DistanceBits = 16;
  localparam int TableLen     = 24;

  localparam int AngleW  = 16;
  localparam int CfgW    = 16;
  localparam int OffsetW = 16;
  localparam int BiasW   = 8;
  localparam int CorrW   = 16;
  localparam int CoordW  = 17;
  localparam int TrigW   = 18;
  localparam int ZW      = 33;
  localparam int XyW     = 34;
  localparam int CfgIdxW = 2;

  localparam int DistW   = DistanceBits;
  localparam int SumW    = DistW + 1;
  localparam int CubeW   = 3 * SumW;
  localparam int RootW   = (CubeW + 1) / 2;
  localparam int RemW    = CubeW + 1;
  localparam int FactorW = 32;
  localparam int PlusW   = RootW + 1;
  localparam int NumHiW  = PlusW + 16 - FactorW;

  localparam logic [AngleW-1:0] TurnCentideg = 16'd36000;
  localparam logic [16:0]       ThetaIntMul  = 17'd119304;
  localparam logic [9:0]        FracMul      = 10'd728;
  localparam logic [9:0]        FracAdd      = 10'd562;
  localparam logic [24:0]       RecipMul     = 25'd30541990;
  localparam int                RecipShift   = 35;

  localparam logic signed [XyW-1:0] GainQ30     = 34'sd652032875;
  localparam logic signed [ZW-1:0]  QuarterTurn = 33'sd1073741824;
  localparam logic signed [ZW-1:0]  HalfTurn    = 33'sd2147483648;

  localparam logic [OffsetW-1:0] OffsetReset = 16'd450;
  localparam logic [BiasW-1:0]   BiasReset   = 8'd10;

  localparam logic [31:0] AtanTab [TableLen] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam int CordicLat = CordicStages + 5;
  localparam int RangeLat  = RootW + 38;
  localparam int AlignLat  = RangeLat - CordicLat;
  localparam int TotalLat  = RangeLat + 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegNumOffset = 2'd0,
    RegDistBias  = 2'd1
  } cfg_reg_e;

endpackage

// ===== rtl/core/lp2c_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lp2c_cordic
// Angle in centidegrees to Q1.16 sine and cosine, pipelined rotation CORDIC.
// ----------------------------------------------------------------------------
module lp2c_cordic (
  input  logic                                  clk_i,
  input  logic [lp2c_pkg::AngleW-1:0]           angle_i,
  output logic signed [lp2c_pkg::TrigW-1:0]     sin_o,
  output logic signed [lp2c_pkg::TrigW-1:0]     cos_o
);

  localparam int N = lp2c_pkg::CordicStages;

  logic [lp2c_pkg::AngleW-1:0] ang_q;
  logic [31:0]                 hi_q;
  logic [31:0]                 hi2_q;
  logic [24:0]                 w_q;
  logic [49:0]                 qm_q;
  logic [31:0]                 theta;
  logic signed [lp2c_pkg::ZW-1:0]  zs;
  logic signed [lp2c_pkg::ZW-1:0]  z_q [N+1];
  logic signed [lp2c_pkg::XyW-1:0] x_q [N+1];
  logic signed [lp2c_pkg::XyW-1:0] y_q [N+1];
  logic                            flip_q [N+1];
  logic signed [lp2c_pkg::TrigW-1:0] sin_q, cos_q;

  function automatic logic signed [lp2c_pkg::TrigW-1:0] round_q16(
    input logic signed [lp2c_pkg::XyW-1:0] v, input logic flip);
    logic signed [lp2c_pkg::XyW-1:0] r;
    r = (v + 34'sd8192) >>> 14;
    if (r > 34'sd65536) r = 34'sd65536;
    if (r < -34'sd65536) r = -34'sd65536;
    if (flip) r = -r;
    return r[lp2c_pkg::TrigW-1:0];
  endfunction

  // reduce modulo one turn, then scale to a binary angle
  always_ff @(posedge clk_i) begin
    ang_q <= (angle_i >= lp2c_pkg::TurnCentideg) ? angle_i - lp2c_pkg::TurnCentideg : angle_i;
    hi_q  <= 32'(33'(ang_q) * 33'(lp2c_pkg::ThetaIntMul));
    w_q   <= 25'(25'(ang_q) * 25'(lp2c_pkg::FracMul) + 25'(lp2c_pkg::FracAdd));
    hi2_q <= hi_q;
    qm_q  <= 50'(w_q) * 50'(lp2c_pkg::RecipMul);
  end

  assign theta = hi2_q + 32'(qm_q[49:lp2c_pkg::RecipShift]);
  assign zs    = $signed({theta[31], theta});

  // fold into the right half plane
  always_ff @(posedge clk_i) begin
    x_q[0] <= lp2c_pkg::GainQ30;
    y_q[0] <= '0;
    if (zs > lp2c_pkg::QuarterTurn) begin
      z_q[0]    <= zs - lp2c_pkg::HalfTurn;
      flip_q[0] <= 1'b1;
    end else if (zs < -lp2c_pkg::QuarterTurn) begin
      z_q[0]    <= zs + lp2c_pkg::HalfTurn;
      flip_q[0] <= 1'b1;
    end else begin
      z_q[0]    <= zs;
      flip_q[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [lp2c_pkg::ZW-1:0] Atan =
      $signed({1'b0, lp2c_pkg::AtanTab[i]});
    always_ff @(posedge clk_i) begin
      flip_q[i+1] <= flip_q[i];
      if (z_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - Atan;
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + Atan;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sin_q <= round_q16(y_q[N], flip_q[N]);
    cos_q <= round_q16(x_q[N], flip_q[N]);
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== rtl/core/lp2c_range.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lp2c_range
// Range correction d*(sqrt(d^3)+A)/sqrt((d+B)^3): pipelined square roots,
// pipelined restoring divider, final scale and saturation.
// ----------------------------------------------------------------------------
module lp2c_range (
  input  logic                              clk_i,
  input  logic [lp2c_pkg::DistW-1:0]        dist_i,
  input  logic [lp2c_pkg::OffsetW-1:0]      offset_i,
  input  logic [lp2c_pkg::BiasW-1:0]        bias_i,
  output logic [lp2c_pkg::CorrW-1:0]        corr_o
);

  localparam int DW = lp2c_pkg::DistW;
  localparam int SW = lp2c_pkg::SumW;
  localparam int RW = lp2c_pkg::RemW;
  localparam int QW = lp2c_pkg::RootW;
  localparam int FW = lp2c_pkg::FactorW;

  logic [DW-1:0]   d0_q, d1_q;
  logic [SW-1:0]   e0_q, e1_q;
  logic [2*DW-1:0] dd_q;
  logic [2*SW-1:0] ee_q;

  logic [RW-1:0] vp_q [QW+1];
  logic [RW-1:0] rp_q [QW+1];
  logic [RW-1:0] vq_q [QW+1];
  logic [RW-1:0] rq_q [QW+1];
  logic [DW-1:0] ds_q [QW+1];

  logic [lp2c_pkg::PlusW-1:0]  plus;
  logic [lp2c_pkg::NumHiW-1:0] num_hi;
  logic [QW-1:0]               root_q;
  logic                        ovf;

  logic [QW-1:0] rem_q  [FW+1];
  logic [QW-1:0] den_q  [FW+1];
  logic [FW-1:0] nlo_q  [FW+1];
  logic [FW-1:0] quo_q  [FW+1];
  logic          ovf_q  [FW+1];
  logic [DW-1:0] dv_q   [FW+1];

  logic [DW+FW-1:0]  prod_q;
  logic [DW-1:0]     dm_q;
  logic              ovfm_q;
  logic [lp2c_pkg::CorrW-1:0] corr_q;

  always_ff @(posedge clk_i) begin
    d0_q <= dist_i;
    e0_q <= SW'(dist_i) + SW'(bias_i);
    d1_q <= d0_q;
    e1_q <= e0_q;
    dd_q <= (2*DW)'(d0_q) * (2*DW)'(d0_q);
    ee_q <= (2*SW)'(e0_q) * (2*SW)'(e0_q);
    vp_q[0] <= RW'(RW'(dd_q) * RW'(d1_q));
    vq_q[0] <= RW'(RW'(ee_q) * RW'(e1_q));
    rp_q[0] <= '0;
    rq_q[0] <= '0;
    ds_q[0] <= d1_q;
  end

  // integer square roots, one result bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_sqrt
    localparam logic [RW-1:0] Bit = RW'(1) << (2 * (QW - 1 - k));
    always_ff @(posedge clk_i) begin
      ds_q[k+1] <= ds_q[k];
      if (vp_q[k] >= rp_q[k] + Bit) begin
        vp_q[k+1] <= vp_q[k] - (rp_q[k] + Bit);
        rp_q[k+1] <= (rp_q[k] >> 1) + Bit;
      end else begin
        vp_q[k+1] <= vp_q[k];
        rp_q[k+1] <= rp_q[k] >> 1;
      end
      if (vq_q[k] >= rq_q[k] + Bit) begin
        vq_q[k+1] <= vq_q[k] - (rq_q[k] + Bit);
        rq_q[k+1] <= (rq_q[k] >> 1) + Bit;
      end else begin
        vq_q[k+1] <= vq_q[k];
        rq_q[k+1] <= rq_q[k] >> 1;
      end
    end
  end

  // numerator (P + A) * 2^16; a quotient of 2^32 or more always saturates
  assign root_q = rq_q[QW][QW-1:0];
  assign plus   = lp2c_pkg::PlusW'(rp_q[QW][QW-1:0]) + lp2c_pkg::PlusW'(offset_i);
  assign num_hi = plus[lp2c_pkg::PlusW-1:16];
  assign ovf    = QW'(num_hi) >= root_q;

  always_ff @(posedge clk_i) begin
    rem_q[0] <= ovf ? '0 : QW'(num_hi);
    den_q[0] <= root_q;
    nlo_q[0] <= {plus[15:0], 16'd0};
    quo_q[0] <= '0;
    ovf_q[0] <= ovf;
    dv_q[0]  <= ds_q[QW];
  end

  for (genvar j = 0; j < FW; j++) begin : g_div
    logic [QW:0] t;
    logic        ge;
    assign t  = {rem_q[j], nlo_q[j][FW-1-j]};
    assign ge = t >= (QW+1)'(den_q[j]);
    always_ff @(posedge clk_i) begin
      rem_q[j+1] <= ge ? QW'(t - (QW+1)'(den_q[j])) : QW'(t);
      quo_q[j+1] <= {quo_q[j][FW-2:0], ge};
      den_q[j+1] <= den_q[j];
      nlo_q[j+1] <= nlo_q[j];
      ovf_q[j+1] <= ovf_q[j];
      dv_q[j+1]  <= dv_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= (DW+FW)'(dv_q[FW]) * (DW+FW)'(quo_q[FW]);
    dm_q   <= dv_q[FW];
    ovfm_q <= ovf_q[FW];
    if (dm_q == '0) begin
      corr_q <= '0;
    end else if (ovfm_q || (prod_q[DW+FW-1:FW] != '0)) begin
      corr_q <= '1;
    end else begin
      corr_q <= prod_q[FW-1:16];
    end
  end

  assign corr_o = corr_q;

endmodule

// ===== rtl/core/lidar_point_polar_to_cartesian_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_polar_to_cartesian_top
// Lidar point range correction and polar to Cartesian conversion.
// ----------------------------------------------------------------------------
// A point is taken whenever start is high; busy never rises, so a point may
// be given every cycle. Each point comes out on done_o in order, held for one
// cycle only; the receiver must take it then. The depth of the pipeline is
// set by the correction path: one stage per square-root bit and one per
// quotient bit of the 32-bit correction factor. The sine and cosine path is
// shorter and is delayed to meet it. Configuration writes take effect at once
// and should be made with no point in flight.
// ----------------------------------------------------------------------------
module lidar_point_polar_to_cartesian_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [lp2c_pkg::DistW-1:0]             distance_mm_i,
  input  logic [lp2c_pkg::AngleW-1:0]            angle_centideg_i,
  output logic                                   done_o,
  output logic [lp2c_pkg::CorrW-1:0]             corrected_mm_o,
  output logic signed [lp2c_pkg::CoordW-1:0]     x_mm_o,
  output logic signed [lp2c_pkg::CoordW-1:0]     y_mm_o,
  input  logic                                   cfg_we_i,
  input  logic [lp2c_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [lp2c_pkg::CfgW-1:0]              cfg_wdata_i
);

  localparam int L  = lp2c_pkg::TotalLat;
  localparam int AL = lp2c_pkg::AlignLat;
  localparam int PW = lp2c_pkg::TrigW + lp2c_pkg::CorrW + 1;

  logic [lp2c_pkg::OffsetW-1:0] offset_q;
  logic [lp2c_pkg::BiasW-1:0]   bias_q;
  logic [L-1:0]                 valid_q;

  logic signed [lp2c_pkg::TrigW-1:0] sin_w, cos_w;
  logic signed [lp2c_pkg::TrigW-1:0] sdl_q [AL];
  logic signed [lp2c_pkg::TrigW-1:0] cdl_q [AL];
  logic [lp2c_pkg::CorrW-1:0]        corr_w, corr_m_q, corr_o_q;
  logic signed [PW-1:0]              px_q, py_q, xr, yr;
  logic signed [lp2c_pkg::CoordW-1:0] x_q, y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= lp2c_pkg::OffsetReset;
      bias_q   <= lp2c_pkg::BiasReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lp2c_pkg::RegNumOffset: offset_q <= cfg_wdata_i;
        lp2c_pkg::RegDistBias:  bias_q   <= cfg_wdata_i[lp2c_pkg::BiasW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[L-2:0], start && !busy};
    end
  end

  assign busy = 1'b0;

  lp2c_cordic u_cordic (
    .clk_i   (clk_i),
    .angle_i (angle_centideg_i),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  lp2c_range u_range (
    .clk_i    (clk_i),
    .dist_i   (distance_mm_i),
    .offset_i (offset_q),
    .bias_i   (bias_q),
    .corr_o   (corr_w)
  );

  // align sine and cosine with the corrected range
  always_ff @(posedge clk_i) begin
    sdl_q[0] <= sin_w;
    cdl_q[0] <= cos_w;
  end

  for (genvar k = 1; k < AL; k++) begin : g_align
    always_ff @(posedge clk_i) begin
      sdl_q[k] <= sdl_q[k-1];
      cdl_q[k] <= cdl_q[k-1];
    end
  end

  assign xr = (px_q + PW'(32768)) >>> 16;
  assign yr = (py_q + PW'(32768)) >>> 16;

  always_ff @(posedge clk_i) begin
    px_q     <= PW'(sdl_q[AL-1]) * $signed({1'b0, corr_w});
    py_q     <= PW'(cdl_q[AL-1]) * $signed({1'b0, corr_w});
    corr_m_q <= corr_w;
    x_q      <= xr[lp2c_pkg::CoordW-1:0];
    y_q      <= lp2c_pkg::CoordW'(-yr);
    corr_o_q <= corr_m_q;
  end

  assign done_o         = valid_q[L-1];
  assign corrected_mm_o = corr_o_q;
  assign x_mm_o         = x_q;
  assign y_mm_o         = y_q;

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, L))
    else $error("result without a matching point");

  a_zero_range_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && corrected_mm_o == '0) |-> (x_mm_o == '0 && y_mm_o == '0))
    else $error("zero range gives a nonzero coordinate");

  a_x_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed({2'b00, corrected_mm_o}) >= 18'(x_mm_o) &&
                -$signed({2'b00, corrected_mm_o}) <= 18'(x_mm_o)))
    else $error("x exceeds corrected range");

  a_y_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed({2'b00, corrected_mm_o}) >= 18'(y_mm_o) &&
                -$signed({2'b00, corrected_mm_o}) <= 18'(y_mm_o)))
    else $error("y exceeds corrected range");

endmodule
